// ===== sv/sis_pkg.sv =====
// ----------------------------------------------------------------------------
// sis_pkg
// Shared types and constants of the sorted integer set.
// ----------------------------------------------------------------------------
package sis_pkg;

  localparam int unsigned SIS_MAX_ELEMENTS = 64;
  localparam int unsigned SIS_VAL_W        = 32;
  localparam int unsigned SIS_CAP_W        = 7;
  localparam int unsigned SIS_CNT_OUT_W    = 7;
  localparam int unsigned SIS_PADDR_W      = 3;
  localparam int unsigned SIS_PDATA_W      = 32;

  localparam logic [SIS_CAP_W-1:0] SIS_CAP_RESET = 7'd64;

  // register index, taken from the word address bit
  localparam logic REG_CAPACITY_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CLEAR  = 2'd3
  } sis_op_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_PRESENT = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_FULL    = 2'd3
  } sis_status_e;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_SEARCH,
    SEQ_DECIDE,
    SEQ_SHIFT,
    SEQ_PLACE,
    SEQ_REPORT
  } sis_state_e;

  typedef struct packed {
    sis_op_e                      op;
    logic signed [SIS_VAL_W-1:0]  value;
  } sis_cmd_t;

  typedef struct packed {
    sis_status_e                status;
    logic [SIS_CNT_OUT_W-1:0]   element_count;
    logic                       is_empty;
  } sis_res_t;

endpackage

// ===== sv/sorted_integer_set.sv =====
// ----------------------------------------------------------------------------
// sorted_integer_set
// Set of distinct signed 32-bit values kept in ascending order in a store.
// Steps: search up to the insertion point, decide, a one-entry-per-cycle shift
// of the entries above it, place, report; the result strobes in the next cycle
// after the report step. A clear goes from idle straight to the report step.
// A new item is taken only while the sequencer is idle (busy low).
// Results cannot be held off. Reset empties the set and sets the limit to 64.
// ----------------------------------------------------------------------------
module sorted_integer_set
  import sis_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = SIS_MAX_ELEMENTS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [SIS_PADDR_W-1:0] paddr,
  input  logic [SIS_PDATA_W-1:0] pwdata,
  output logic [SIS_PDATA_W-1:0] prdata,
  output logic                   pready,
  input  logic                   start,
  output logic                   busy,
  input  sis_cmd_t               cmd_i,
  output logic                   done_o,
  output sis_res_t               result_o
);

  localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  logic [SIS_CAP_W-1:0] cap;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [SIS_VAL_W-1:0] wr_data;
  logic [AW-1:0]        rd_addr;
  logic [SIS_VAL_W-1:0] rd_data;

  sis_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cap_o   (cap)
  );

  sis_store #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  sis_seq #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .cmd_i     (cmd_i),
    .cap_i     (cap),
    .done_o    (done_o),
    .result_o  (result_o),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data)
  );

endmodule

// ===== sv/sis_cfg.sv =====
// ----------------------------------------------------------------------------
// sis_cfg
// Configuration register block holding the capacity limit.
// ----------------------------------------------------------------------------
module sis_cfg
  import sis_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [SIS_PADDR_W-1:0] paddr,
  input  logic [SIS_PDATA_W-1:0] pwdata,
  output logic [SIS_PDATA_W-1:0] prdata,
  output logic                   pready,
  output logic [SIS_CAP_W-1:0]   cap_o
);

  logic [SIS_CAP_W-1:0] cap_q, cap_d;
  logic                 reg_sel;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_CAPACITY_LIMIT);
  assign wr_en   = psel && penable && pwrite && pready && reg_sel;

  always_comb begin
    cap_d = cap_q;
    if (wr_en) begin
      cap_d = pwdata[SIS_CAP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= SIS_CAP_RESET;
    end else begin
      cap_q <= cap_d;
    end
  end

  assign prdata = reg_sel ? SIS_PDATA_W'(cap_q) : '0;
  assign cap_o  = cap_q;

endmodule

// ===== sv/sis_store.sv =====
// ----------------------------------------------------------------------------
// sis_store
// Single write, single read value store with registered read data.
// ----------------------------------------------------------------------------
module sis_store
  import sis_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = SIS_MAX_ELEMENTS,
  localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  logic [SIS_VAL_W-1:0] wr_data_i,
  input  logic [AW-1:0]        rd_addr_i,
  output logic [SIS_VAL_W-1:0] rd_data_o
);

  logic [SIS_VAL_W-1:0] mem [MAX_ELEMENTS];
  logic [SIS_VAL_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/sis_seq.sv =====
// ----------------------------------------------------------------------------
// sis_seq
// Sequencer: linear search with one shared signed comparator, then an
// entry-by-entry shift through the store, then the result.
// ----------------------------------------------------------------------------
module sis_seq
  import sis_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = SIS_MAX_ELEMENTS,
  localparam int unsigned AW    = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1,
  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1),
  localparam int unsigned LW    = (CNT_W > SIS_CAP_W) ? CNT_W : SIS_CAP_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  sis_cmd_t             cmd_i,
  input  logic [SIS_CAP_W-1:0] cap_i,
  output logic                 done_o,
  output sis_res_t             result_o,
  output logic                 wr_en_o,
  output logic [AW-1:0]        wr_addr_o,
  output logic [SIS_VAL_W-1:0] wr_data_o,
  output logic [AW-1:0]        rd_addr_o,
  input  logic [SIS_VAL_W-1:0] rd_data_i
);

  sis_state_e state_q, state_d;
  sis_op_e    op_q, op_d;
  sis_status_e status_q, status_d;
  logic signed [SIS_VAL_W-1:0] val_q, val_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] issue_q, issue_d;
  logic [CNT_W-1:0] pend_idx_q, pend_idx_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic             pend_q, pend_d;
  logic             present_q, present_d;
  logic             done_q, done_d;
  sis_res_t         res_q, res_d;

  logic             cmp_ge, cmp_eq;
  logic             search_hit, search_end;
  logic             shift_more;
  logic             full;
  logic [CNT_W-1:0] wr_idx;
  logic [CNT_W-1:0] rd_idx;

  // shared signed comparator
  assign cmp_ge = $signed(rd_data_i) >= val_q;
  assign cmp_eq = $signed(rd_data_i) == val_q;

  assign search_hit = pend_q && cmp_ge;
  assign search_end = !search_hit && (issue_q == count_q);
  assign shift_more = (op_q == OP_INSERT) ? (issue_q > pos_q) : (issue_q < count_q);
  assign full = (LW'(count_q) >= LW'(cap_i)) || (count_q >= CNT_W'(MAX_ELEMENTS));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SEQ_IDLE: begin
        if (start) begin
          state_d = (cmd_i.op == OP_CLEAR) ? SEQ_REPORT : SEQ_SEARCH;
        end
      end
      SEQ_SEARCH: begin
        if (search_hit || search_end) begin
          state_d = SEQ_DECIDE;
        end
      end
      SEQ_DECIDE: begin
        if ((op_q == OP_INSERT && !present_q && !full) ||
            (op_q == OP_REMOVE && present_q)) begin
          state_d = SEQ_SHIFT;
        end else begin
          state_d = SEQ_REPORT;
        end
      end
      SEQ_SHIFT: begin
        if (!shift_more && !pend_q) begin
          state_d = SEQ_PLACE;
        end
      end
      SEQ_PLACE:  state_d = SEQ_REPORT;
      SEQ_REPORT: state_d = SEQ_IDLE;
      default:    state_d = SEQ_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    op_d       = op_q;
    val_d      = val_q;
    status_d   = status_q;
    count_d    = count_q;
    issue_d    = issue_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;
    pos_d      = pos_q;
    present_d  = present_q;
    done_d     = 1'b0;
    res_d      = res_q;
    wr_en_o    = 1'b0;
    wr_idx     = pend_idx_q;
    wr_data_o  = rd_data_i;
    rd_idx     = issue_q;
    unique case (state_q)
      SEQ_IDLE: begin
        if (start) begin
          op_d     = cmd_i.op;
          val_d    = cmd_i.value;
          status_d = ST_DONE;
          issue_d  = '0;
          pend_d   = 1'b0;
          if (cmd_i.op == OP_CLEAR) begin
            count_d = '0;
          end
        end
      end
      SEQ_SEARCH: begin
        rd_idx = issue_q;
        if (search_hit) begin
          pos_d     = pend_idx_q;
          present_d = cmp_eq;
          pend_d    = 1'b0;
        end else if (search_end) begin
          pos_d     = count_q;
          present_d = 1'b0;
          pend_d    = 1'b0;
        end else begin
          pend_d     = 1'b1;
          pend_idx_d = issue_q;
          issue_d    = issue_q + 1'b1;
        end
      end
      SEQ_DECIDE: begin
        pend_d = 1'b0;
        unique case (op_q)
          OP_INSERT: begin
            if (present_q) begin
              status_d = ST_PRESENT;
            end else if (full) begin
              status_d = ST_FULL;
            end else begin
              issue_d = count_q;
            end
          end
          OP_REMOVE: begin
            if (!present_q) begin
              status_d = ST_ABSENT;
            end else begin
              issue_d = pos_q + 1'b1;
            end
          end
          OP_QUERY: status_d = present_q ? ST_DONE : ST_ABSENT;
          default:  status_d = ST_DONE;
        endcase
      end
      SEQ_SHIFT: begin
        if (pend_q) begin
          wr_en_o   = 1'b1;
          wr_idx    = pend_idx_q;
          wr_data_o = rd_data_i;
        end
        if (shift_more) begin
          pend_d = 1'b1;
          if (op_q == OP_INSERT) begin
            rd_idx     = issue_q - 1'b1;
            pend_idx_d = issue_q;
            issue_d    = issue_q - 1'b1;
          end else begin
            rd_idx     = issue_q;
            pend_idx_d = issue_q - 1'b1;
            issue_d    = issue_q + 1'b1;
          end
        end else begin
          pend_d = 1'b0;
        end
      end
      SEQ_PLACE: begin
        if (op_q == OP_INSERT) begin
          wr_en_o   = 1'b1;
          wr_idx    = pos_q;
          wr_data_o = val_q;
          count_d   = count_q + 1'b1;
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      SEQ_REPORT: begin
        done_d              = 1'b1;
        res_d.status        = status_q;
        res_d.element_count = SIS_CNT_OUT_W'(LW'(count_q));
        res_d.is_empty      = (count_q == '0);
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    val_q      <= val_d;
    status_q   <= status_d;
    issue_q    <= issue_d;
    pend_idx_q <= pend_idx_d;
    pos_q      <= pos_d;
    present_q  <= present_d;
    res_q      <= res_d;
  end

  assign busy      = (state_q != SEQ_IDLE);
  assign done_o    = done_q;
  assign result_o  = res_q;
  assign wr_addr_o = wr_idx[AW-1:0];
  assign rd_addr_o = rd_idx[AW-1:0];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ELEMENTS))
    else $error("element count above store depth");

  a_done_after_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == SEQ_REPORT))
    else $error("result strobe without report step");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the sequencer busy");

  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> (wr_idx < CNT_W'(MAX_ELEMENTS)) && (wr_idx <= count_q))
    else $error("store write outside the held range");

endmodule

// ===== tb/sorted_integer_set_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_integer_set_tb
// Self-checking bench for the sorted integer set. A queue-based shadow set
// predicts status, count and empty flag for every command item; results are
// checked in order as they strobe out. Directed tests cover the empty set,
// the value extremes, duplicates, clear and the capacity register; random
// phases fill the set, drain it, shrink the limit below the count and mix
// all operations under random sender gaps.
// ----------------------------------------------------------------------------
module sorted_integer_set_tb;
  import sis_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned END_SETTLE  = 2 * SIS_MAX_ELEMENTS + 8;

  localparam logic [SIS_PADDR_W-1:0] ADDR_CAP_LIMIT = {REG_CAPACITY_LIMIT, 2'b00};
  localparam logic [SIS_PADDR_W-1:0] ADDR_UNUSED    = {~REG_CAPACITY_LIMIT, 2'b00};

  localparam logic signed [SIS_VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [SIS_VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [SIS_PADDR_W-1:0] paddr;
  logic [SIS_PDATA_W-1:0] pwdata;
  logic [SIS_PDATA_W-1:0] prdata;
  logic                   pready;
  logic                   start;
  logic                   busy;
  sis_cmd_t               cmd_i;
  logic                   done_o;
  sis_res_t               result_o;

  int unsigned                   idle_pct = 35;
  int unsigned                   cycle_cnt = 0;
  int unsigned                   mismatches = 0;
  sis_res_t                      expected_results[$];
  logic signed [SIS_VAL_W-1:0]   held_values[$];
  logic [SIS_CAP_W-1:0]          cap_limit = SIS_CAP_RESET;
  logic signed [SIS_VAL_W-1:0]   value_pool[$];

  sorted_integer_set i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .start    (start),
    .busy     (busy),
    .cmd_i    (cmd_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("Verification failed");
      $finish;
    end
  end

  function automatic sis_res_t apply_set_op(input sis_cmd_t c);
    logic signed [SIS_VAL_W-1:0] v;
    int unsigned                 pos;
    int unsigned                 lim;
    bit                          present;
    sis_res_t                    r;
    v   = c.value;
    pos = 0;
    while (pos < held_values.size() && held_values[pos] < v) pos++;
    present  = (pos < held_values.size()) && (held_values[pos] == v);
    lim      = (cap_limit > SIS_MAX_ELEMENTS) ? SIS_MAX_ELEMENTS : cap_limit;
    r.status = ST_DONE;
    case (c.op)
      OP_INSERT: begin
        if (present) r.status = ST_PRESENT;
        else if (held_values.size() >= lim) r.status = ST_FULL;
        else held_values.insert(pos, v);
      end
      OP_REMOVE: begin
        if (!present) r.status = ST_ABSENT;
        else held_values.delete(pos);
      end
      OP_QUERY: begin
        if (!present) r.status = ST_ABSENT;
      end
      default: begin
        held_values.delete();
      end
    endcase
    r.element_count = SIS_CNT_OUT_W'(held_values.size());
    r.is_empty      = (held_values.size() == 0);
    return r;
  endfunction

  always @(posedge clk_i) begin : result_check
    sis_res_t want;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, actual %p", $time, result_o);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (result_o.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   result_o.status);
          mismatches++;
        end
        if (result_o.element_count !== want.element_count) begin
          $display("%0t: element_count expected %0d actual %0d", $time,
                   want.element_count, result_o.element_count);
          mismatches++;
        end
        if (result_o.is_empty !== want.is_empty) begin
          $display("%0t: is_empty expected %0b actual %0b", $time, want.is_empty,
                   result_o.is_empty);
          mismatches++;
        end
      end
    end
  end

  task automatic send_cmd(input sis_op_e op, input logic signed [SIS_VAL_W-1:0] val);
    sis_cmd_t c;
    c.op    = op;
    c.value = val;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    expected_results.push_back(apply_set_op(c));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0 || busy !== 1'b0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [SIS_PADDR_W-1:0] addr,
                           input logic [SIS_PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    if (addr[2] == REG_CAPACITY_LIMIT) cap_limit = data[SIS_CAP_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_limit_readback();
    logic [SIS_PDATA_W-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_CAP_LIMIT;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (got !== SIS_PDATA_W'(cap_limit)) begin
      $display("%0t: capacity_limit readback expected %0d actual %0d", $time,
               cap_limit, got);
      mismatches++;
    end
  endtask

  task automatic set_limit(input logic [SIS_PDATA_W-1:0] lim);
    wait_drained();
    cfg_write(ADDR_CAP_LIMIT, lim);
    check_limit_readback();
  endtask

  task automatic build_pool(input int unsigned n);
    value_pool.delete();
    for (int unsigned i = 0; i < n; i++) begin
      case (i)
        0:       value_pool.push_back(VAL_MIN);
        1:       value_pool.push_back(VAL_MAX);
        2:       value_pool.push_back('0);
        3:       value_pool.push_back('1);
        default: begin
          if ($urandom_range(3) == 0) value_pool.push_back($urandom_range(40) - 20);
          else value_pool.push_back($urandom);
        end
      endcase
    end
  endtask

  function automatic logic signed [SIS_VAL_W-1:0] pick_value();
    if ($urandom_range(99) < 80) return value_pool[$urandom_range(value_pool.size() - 1)];
    return $urandom;
  endfunction

  task automatic run_random(input int unsigned n_items, input int unsigned pool_n,
                            input int unsigned w_ins, input int unsigned w_rem,
                            input int unsigned w_qry, input int unsigned w_clr);
    int unsigned pick;
    sis_op_e     op;
    build_pool(pool_n);
    repeat (n_items) begin
      pick = $urandom_range(w_ins + w_rem + w_qry + w_clr - 1);
      if (pick < w_ins) op = OP_INSERT;
      else if (pick < w_ins + w_rem) op = OP_REMOVE;
      else if (pick < w_ins + w_rem + w_qry) op = OP_QUERY;
      else op = OP_CLEAR;
      send_cmd(op, pick_value());
    end
  endtask

  task automatic test_empty_set();
    send_cmd(OP_QUERY, '0);
    send_cmd(OP_REMOVE, '0);
  endtask

  task automatic test_insert_remove();
    send_cmd(OP_INSERT, '0);
    send_cmd(OP_INSERT, VAL_MAX);
    send_cmd(OP_INSERT, VAL_MIN);
    send_cmd(OP_INSERT, '1);
    send_cmd(OP_INSERT, 32'sd1);
    send_cmd(OP_INSERT, VAL_MIN);
    send_cmd(OP_QUERY, VAL_MAX);
    send_cmd(OP_QUERY, 32'sd2);
    send_cmd(OP_REMOVE, '1);
    send_cmd(OP_REMOVE, '1);
    send_cmd(OP_REMOVE, VAL_MIN);
    send_cmd(OP_REMOVE, VAL_MAX);
    send_cmd(OP_QUERY, 32'sd1);
  endtask

  task automatic test_clear();
    send_cmd(OP_CLEAR, '1);
    send_cmd(OP_CLEAR, '0);
  endtask

  task automatic test_capacity_limit();
    set_limit(2);
    send_cmd(OP_INSERT, 32'sd5);
    send_cmd(OP_INSERT, 32'sd7);
    send_cmd(OP_INSERT, 32'sd6);
    send_cmd(OP_INSERT, 32'sd5);
    set_limit(0);
    send_cmd(OP_REMOVE, 32'sd5);
    send_cmd(OP_INSERT, 32'sd9);
  endtask

  task automatic test_register_map();
    wait_drained();
    cfg_write(ADDR_UNUSED, 32'd3);
    check_limit_readback();
    send_cmd(OP_INSERT, 32'sd11);
    send_cmd(OP_CLEAR, '0);
  endtask

  task automatic test_random_fill();
    set_limit(127);
    run_random(140, 90, 70, 10, 20, 0);
  endtask

  task automatic test_random_drain();
    run_random(70, 90, 15, 60, 25, 0);
  endtask

  task automatic test_limit_below_count();
    set_limit(8);
    run_random(120, 90, 40, 30, 25, 5);
  endtask

  task automatic test_tiny_limits();
    set_limit(1);
    run_random(80, 4, 45, 25, 25, 5);
    set_limit(0);
    run_random(60, 6, 50, 20, 25, 5);
  endtask

  task automatic test_random_mixed();
    set_limit(20);
    idle_pct = 0;
    run_random(100, 30, 45, 25, 25, 5);
    idle_pct = 35;
    repeat (3) begin
      run_random(25, 30, 45, 25, 25, 5);
      wait_drained();
    end
    set_limit(100);
    run_random(40, 90, 60, 15, 20, 5);
  endtask

  initial begin
    rst_ni  <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    start   <= 1'b0;
    cmd_i   <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_set();
    test_insert_remove();
    test_clear();
    test_capacity_limit();
    test_register_map();
    test_random_fill();
    test_random_drain();
    test_limit_below_count();
    test_tiny_limits();
    test_random_mixed();

    wait_drained();
    repeat (END_SETTLE) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
